// File: hw/rtl/sorted_edge_table_defines.svh
// ---------------------------------------------------------------------------
// Sorted edge table assertion macros
// Shared concurrent check wrappers, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_EDGE_TABLE_DEFINES_SVH
`define SORTED_EDGE_TABLE_DEFINES_SVH

// same-cycle implication
`define SET_CHK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SET_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/set_pkg.sv
// ---------------------------------------------------------------------------
// Sorted edge table package
// Sizes, status codes, controller/datapath interface types and field helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package set_pkg;

    localparam int MAX_EDGES  = 32;
    localparam int CHILD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_EDGES);
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);

    localparam int LETTER_W   = 8;
    localparam int CHILD_F_W  = 16;
    localparam int POS_F_W    = 5;
    localparam int CNT_F_W    = 6;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_REPLACED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic    load;
        logic    rd_mid;
        logic    step;
        logic    shift_start;
        logic    shift;
        logic    repl;
        logic    ins;
        logic    emit;
        status_t st;
    } set_cmd_t;

    typedef struct packed {
        logic is_set;
        logic srch_end;
        logic eq;
        logic full;
        logic shift_end;
        logic out_free;
    } set_sts_t;

    function automatic logic [CHILD_BITS-1:0] child_keep(input logic [CHILD_F_W-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[CHILD_BITS-1:0];
    endfunction

    function automatic logic [CHILD_F_W-1:0] child_field(input logic [CHILD_BITS-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[CHILD_F_W-1:0];
    endfunction

    function automatic logic [POS_F_W-1:0] pos_field(input logic [IDX_W-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[POS_F_W-1:0];
    endfunction

    function automatic logic [CNT_F_W-1:0] cnt_field(input logic [CNT_W-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[CNT_F_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sorted_edge_table.sv
// Each item runs a binary search, each probe a read then a compare; an insert then runs a
//   shift-up sweep over the moved entries and a write. The result is posted once the output
//   register is free.
// Items are taken one at a time; s_tready returns in the cycle after the result is posted.
// Reset clears the edge count and handshake state; table contents are not cleared.
// ---------------------------------------------------------------------------
// Sorted edge table
// Per-node edge list kept sorted by letter, with lookup, replace and insert.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_edge_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // letter[7:0], child_in[23:8]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // child_out[15:0], position[20:16], edge_count[26:21]
    output logic [2:0]  m_tuser    // status
);
    import set_pkg::*;

    set_cmd_t             cmd;
    set_sts_t             sts;
    status_t              status;
    logic [CHILD_F_W-1:0] child_out;
    logic [POS_F_W-1:0]   position;
    logic [CNT_F_W-1:0]   edge_count;

    set_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    set_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (s_tuser),
        .letter     (s_tdata[7:0]),
        .child_in   (s_tdata[23:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .status     (status),
        .child_out  (child_out),
        .position   (position),
        .edge_count (edge_count)
    );

    assign m_tdata = {5'b0, edge_count, position, child_out};
    assign m_tuser = status;

endmodule

`default_nettype wire

// File: hw/rtl/set_ctrl.sv
// ---------------------------------------------------------------------------
// Sorted edge table controller
// Sequences search probes, the shift-up sweep, the write and the result.
// ---------------------------------------------------------------------------
`default_nettype none

module set_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  set_pkg::set_sts_t sts,
    output set_pkg::set_cmd_t cmd
);
    import set_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CMP   = 6'b000100,
        S_SHIFT = 6'b001000,
        S_INS   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.st     = st_reg;
        s_tready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.srch_end)
                begin
                    if (!sts.is_set)
                    begin
                        st_next    = ST_MISS;
                        state_next = S_DONE;
                    end
                    else if (sts.full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.eq)
                begin
                    if (sts.is_set)
                    begin
                        cmd.repl = 1'b1;
                        st_next  = ST_REPLACED;
                    end
                    else
                    begin
                        st_next = ST_HIT;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_end)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                st_next    = ST_INSERTED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_HIT;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/set_dp.sv
// ---------------------------------------------------------------------------
// Sorted edge table datapath
// Letter and child memories, search bounds, shift pointer, result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_edge_table_defines.svh"

module set_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  set_pkg::set_cmd_t               cmd,
    output set_pkg::set_sts_t               sts,
    input  logic                            operation,
    input  logic [set_pkg::LETTER_W-1:0]    letter,
    input  logic [set_pkg::CHILD_F_W-1:0]   child_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output set_pkg::status_t                status,
    output logic [set_pkg::CHILD_F_W-1:0]   child_out,
    output logic [set_pkg::POS_F_W-1:0]     position,
    output logic [set_pkg::CNT_F_W-1:0]     edge_count
);
    import set_pkg::*;

    logic [LETTER_W-1:0]   letters_mem  [MAX_EDGES];
    logic [CHILD_BITS-1:0] children_mem [MAX_EDGES];

    logic                  op_reg;
    logic [LETTER_W-1:0]   letter_reg;
    logic [CHILD_BITS-1:0] child_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [LETTER_W-1:0]   rd_letter_reg;
    logic [CHILD_BITS-1:0] rd_child_reg;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg;
    logic [CHILD_F_W-1:0]  child_out_reg;
    logic [POS_F_W-1:0]    position_reg;
    logic [CNT_F_W-1:0]    edge_count_reg;

    logic [CNT_W:0]        mid_sum;
    logic [CNT_W-1:0]      mid_c;
    logic [CNT_W-1:0]      ptr_dec;
    logic                  shift_go;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  let_we, chd_we;
    logic [IDX_W-1:0]      let_wa, chd_wa;
    logic [LETTER_W-1:0]   let_wd;
    logic [CHILD_BITS-1:0] chd_wd;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c    = mid_sum[CNT_W:1];
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign shift_go = cmd.shift && (ptr_reg != lo_reg);

    assign sts.is_set    = op_reg;
    assign sts.srch_end  = (lo_reg >= hi_reg);
    assign sts.eq        = (rd_letter_reg == letter_reg);
    assign sts.full      = (count_reg == CNT_W'(MAX_EDGES));
    assign sts.shift_end = (ptr_reg == lo_reg) && !pend_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_en   = cmd.rd_mid || shift_go;
        rd_addr = cmd.rd_mid ? mid_c[IDX_W-1:0] : ptr_dec[IDX_W-1:0];

        let_we = 1'b0;
        chd_we = 1'b0;
        let_wa = pend_addr_reg;
        chd_wa = pend_addr_reg;
        let_wd = rd_letter_reg;
        chd_wd = rd_child_reg;
        if (cmd.shift && pend_reg)
        begin
            let_we = 1'b1;
            chd_we = 1'b1;
        end
        else if (cmd.ins)
        begin
            let_we = 1'b1;
            chd_we = 1'b1;
            let_wa = lo_reg[IDX_W-1:0];
            chd_wa = lo_reg[IDX_W-1:0];
            let_wd = letter_reg;
            chd_wd = child_reg;
        end
        else if (cmd.repl)
        begin
            chd_we = 1'b1;
            chd_wa = mid_reg;
            chd_wd = child_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (let_we)
        begin
            letters_mem[let_wa] <= let_wd;
        end
        if (chd_we)
        begin
            children_mem[chd_wa] <= chd_wd;
        end
        if (rd_en)
        begin
            rd_letter_reg <= letters_mem[rd_addr];
            rd_child_reg  <= children_mem[rd_addr];
        end
    end

    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.rd_mid)
        begin
            mid_next = mid_c[IDX_W-1:0];
        end
        if (cmd.step)
        begin
            if (rd_letter_reg > letter_reg)
            begin
                hi_next = CNT_W'(mid_reg);
            end
            else
            begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
        end
        if (cmd.shift_start)
        begin
            ptr_next  = count_reg;
            pend_next = 1'b0;
        end
        if (cmd.shift)
        begin
            pend_next = shift_go;
            if (shift_go)
            begin
                pend_addr_next = ptr_reg[IDX_W-1:0];
                ptr_next       = ptr_dec;
            end
        end
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            letter_reg <= letter;
            child_reg  <= child_keep(child_in);
        end
        if (cmd.emit)
        begin
            status_reg     <= cmd.st;
            edge_count_reg <= cnt_field(count_reg);
            unique case (cmd.st)
                ST_HIT:
                begin
                    child_out_reg <= child_field(rd_child_reg);
                    position_reg  <= pos_field(mid_reg);
                end
                ST_REPLACED:
                begin
                    child_out_reg <= child_field(child_reg);
                    position_reg  <= pos_field(mid_reg);
                end
                ST_INSERTED:
                begin
                    child_out_reg <= child_field(child_reg);
                    position_reg  <= pos_field(lo_reg[IDX_W-1:0]);
                end
                default:
                begin
                    child_out_reg <= '0;
                    position_reg  <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign child_out  = child_out_reg;
    assign position   = position_reg;
    assign edge_count = edge_count_reg;

    `SET_CHK(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_EDGES), "edge count above table size")
    `SET_CHK_NXT(a_ins_count, cmd.ins, count_reg == $past(count_reg) + CNT_W'(1), "insert did not bump count")
    `SET_CHK(a_probe_range, cmd.rd_mid, (lo_reg < hi_reg) && (hi_reg <= count_reg), "probe outside search window")
    `SET_CHK(a_shift_ptr, cmd.shift, (ptr_reg >= lo_reg) && (ptr_reg <= count_reg), "shift pointer out of range")

endmodule

`default_nettype wire

// File: tb/sv/sorted_edge_table_test.sv
// ---------------------------------------------------------------------------
// Sorted edge table testbench
// Streams lookup and set items into the edge table under random stalls on
// both sides and checks every result against an in-bench table model.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_edge_table_test;
    import set_pkg::*;

    localparam bit OP_LOOKUP     = 1'b0;
    localparam bit OP_SET        = 1'b1;
    localparam int RANDOM_ITEMS  = 1640;
    localparam int FILL_AFTER    = 900;
    localparam int DRAIN_CYCLES  = 60;
    localparam int MAX_GAP       = 14;

    typedef struct {
        status_t               status;
        logic [CHILD_F_W-1:0]  child;
        logic [POS_F_W-1:0]    position;
        logic [CNT_F_W-1:0]    edge_count;
    } edge_result_t;

    class edge_table_board;
        logic [LETTER_W-1:0]  letters [MAX_EDGES];
        logic [CHILD_F_W-1:0] children [MAX_EDGES];
        int unsigned          held;
        edge_result_t         pending_results [$];
        int unsigned          errors;
        int unsigned          status_seen [5];

        function new();
            held   = 0;
            errors = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // binary search; slot gets the sorted insertion point on a miss
        function int locate(input logic [LETTER_W-1:0] letter, output int slot);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = int'(held) - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (letters[mid] == letter)
                begin
                    slot = mid;
                    return mid;
                end
                if (letters[mid] > letter)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            slot = lo;
            return -1;
        endfunction

        function void predict_item(input bit op, input logic [LETTER_W-1:0] letter,
                                   input logic [CHILD_F_W-1:0] child_in);
            edge_result_t r;
            int           idx;
            int           slot;
            idx        = locate(letter, slot);
            r.child    = '0;
            r.position = '0;
            if (op == OP_LOOKUP)
            begin
                if (idx >= 0)
                begin
                    r.status   = ST_HIT;
                    r.child    = children[idx];
                    r.position = POS_F_W'(idx);
                end
                else
                    r.status = ST_MISS;
            end
            else if (idx >= 0)
            begin
                children[idx] = child_in;
                r.status      = ST_REPLACED;
                r.child       = child_in;
                r.position    = POS_F_W'(idx);
            end
            else if (held >= MAX_EDGES)
                r.status = ST_FULL;
            else
            begin
                for (int i = int'(held); i > slot; i--)
                begin
                    letters[i]  = letters[i-1];
                    children[i] = children[i-1];
                end
                letters[slot]  = letter;
                children[slot] = child_in;
                held++;
                r.status   = ST_INSERTED;
                r.child    = child_in;
                r.position = POS_F_W'(slot);
            end
            r.edge_count = CNT_F_W'(held);
            status_seen[int'(r.status)]++;
            pending_results.push_back(r);
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(input logic [2:0] status,
                                   input logic [CHILD_F_W-1:0] child,
                                   input logic [POS_F_W-1:0] position,
                                   input logic [CNT_F_W-1:0] edge_count);
            edge_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0h child %0h",
                         $time, status, child);
                return;
            end
            want = pending_results.pop_front();
            compare("status", 32'(want.status), 32'(status));
            compare("child_out", 32'(want.child), 32'(child));
            compare("position", 32'(want.position), 32'(position));
            compare("edge_count", 32'(want.edge_count), 32'(edge_count));
        endfunction

        function logic [LETTER_W-1:0] pick_present();
            if (held == 0)
                return LETTER_W'($urandom_range(0, 255));
            return letters[$urandom_range(0, held - 1)];
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // letter[7:0], child_in[23:8]
    logic        s_tuser  = 1'b0; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // child_out[15:0], position[20:16], edge_count[26:21]
    logic [2:0]  m_tuser;         // status

    edge_table_board board = new();
    bit          send_burst = 1'b0;
    bit          take_burst = 1'b0;
    int unsigned sent       = 0;

    sorted_edge_table DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #16_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // bursts with no idling come and go at random
    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_item(input bit op, input logic [LETTER_W-1:0] letter,
                             input logic [CHILD_F_W-1:0] child);
        int unsigned gap;
        gap = draw_gap(send_burst);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {child, letter};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        board.predict_item(op, letter, child);
        sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // mostly hits and replaces on live letters; new letters are rare until late
    task automatic random_item(input int n);
        int unsigned           pick;
        int unsigned           new_weight;
        logic [LETTER_W-1:0]   letter;
        int                    slot;
        new_weight = (board.held < MAX_EDGES && n < FILL_AFTER) ? 3 : 25;
        pick       = $urandom_range(0, 99);
        if (pick < new_weight)
        begin
            do
                letter = LETTER_W'($urandom_range(0, 255));
            while (board.locate(letter, slot) >= 0);
            send_item(OP_SET, letter, CHILD_F_W'($urandom));
        end
        else if (pick < new_weight + 15)
            send_item(OP_LOOKUP, LETTER_W'($urandom_range(0, 255)), CHILD_F_W'($urandom));
        else if (pick < new_weight + 55)
            send_item(OP_LOOKUP, board.pick_present(), CHILD_F_W'($urandom));
        else
            send_item(OP_SET, board.pick_present(), CHILD_F_W'($urandom));
    endtask

    initial
    begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(take_burst);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            board.check_result(m_tuser, m_tdata[15:0], m_tdata[20:16], m_tdata[26:21]);
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, extreme letters, zero and all-ones children, shifts
        send_item(OP_LOOKUP, 8'h00, 16'h0000);
        send_item(OP_LOOKUP, 8'hFF, 16'hFFFF);
        send_item(OP_SET,    8'h80, 16'h0000);
        send_item(OP_LOOKUP, 8'h80, 16'h1234);
        send_item(OP_SET,    8'hFF, 16'hFFFF);
        send_item(OP_SET,    8'h00, 16'hAAAA);
        send_item(OP_SET,    8'h80, 16'h5555);
        send_item(OP_LOOKUP, 8'h00, 16'h0000);
        send_item(OP_LOOKUP, 8'hFF, 16'h0000);
        send_item(OP_LOOKUP, 8'h7F, 16'hFFFF);
        send_item(OP_SET,    8'h01, 16'h0001);
        send_item(OP_SET,    8'hFE, 16'h8000);
        send_item(OP_SET,    8'h55, 16'h7FFF);
        send_item(OP_LOOKUP, 8'h80, 16'h0000);
        send_item(OP_LOOKUP, 8'h55, 16'h0000);
        send_item(OP_LOOKUP, 8'hAA, 16'h0000);
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 300 == 299)
                hold_until_drained();
            random_item(n);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items; table ended with %0d edges.", sent, board.held);
        $display("Results: %0d hit, %0d miss, %0d inserted, %0d replaced, %0d full.",
                 board.status_seen[ST_HIT], board.status_seen[ST_MISS],
                 board.status_seen[ST_INSERTED], board.status_seen[ST_REPLACED],
                 board.status_seen[ST_FULL]);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/set_pkg.sv
hw/rtl/set_ctrl.sv
hw/rtl/set_dp.sv
hw/rtl/sorted_edge_table.sv
tb/sv/sorted_edge_table_test.sv
